// ----- design/dgsp_pkg.sv -----
// Package for the dense graph shortest path block.
// Field widths, request codes and the distance entry type.
// No dependencies.
`default_nettype none

package dgsp_pkg;

  localparam int VTX_W      = 4;
  localparam int WGT_W      = 16;
  localparam int DIST_W     = 20;
  localparam int MAX_REPORT = 16;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  typedef struct packed {
    logic              settled;
    logic              reached;
    logic [DIST_W-1:0] dist_val;
  } dist_entry_t;

  typedef struct packed {
    logic        wr;
    dist_entry_t entry;
  } relax_res_t;

endpackage

`default_nettype wire

// ----- design/dgsp_ram.sv -----
// Generic simple dual port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module dgsp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/dgsp_relax.sv -----
// Edge relaxation: saturating candidate distance and the update decision.
// Depends on dgsp_pkg.
`default_nettype none

module dgsp_relax (
  input  logic [dgsp_pkg::DIST_W-1:0] best,
  input  logic [dgsp_pkg::WGT_W-1:0]  wgt,
  input  dgsp_pkg::dist_entry_t       cur,
  input  logic                        is_self,
  output dgsp_pkg::relax_res_t        res
);
  import dgsp_pkg::*;

  logic [DIST_W:0]   sum;
  logic [DIST_W-1:0] cand;

  assign sum  = {1'b0, best} + (DIST_W + 1)'(wgt);
  assign cand = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];

  always_comb begin
    res.wr             = 1'b0;
    res.entry.settled  = 1'b0;
    res.entry.reached  = 1'b1;
    res.entry.dist_val = cand;
    priority if (is_self) begin
      res.wr             = 1'b1;
      res.entry.settled  = 1'b1;
      res.entry.dist_val = best;
    end else if (cur.settled || wgt == '0) begin
      res.wr = 1'b0;
    end else if (!cur.reached || cand < cur.dist_val) begin
      res.wr = 1'b1;
    end else begin
      res.wr = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- design/dense_graph_shortest_paths.sv -----
// Top level: single source shortest paths over an adjacency matrix in RAM.
// Depends on dgsp_pkg, dgsp_ram, dgsp_relax.
//
//   channel | direction | handshake             | payload
//   in_     | input     | in_valid / in_ready   | req_type, row, col, weight, source
//   out_    | output    | out_valid / out_ready | vertex, distance, reachable, last
//
// After reset all N*N weight RAM entries are swept to zero, with in_ready low.
// A run initializes the distance RAM, then per settled vertex makes one scan and
// one relax pass through the distance RAM read port, then a final scan, then
// reads out each result in S_OUT_RD, S_OUT_LD and S_OUT_HOLD, where it waits on
// output stalls. One item is in work at a time.
`default_nettype none

module dense_graph_shortest_paths #(
  parameter int NUM_VERTICES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_req_type,
  input  logic [dgsp_pkg::VTX_W-1:0]    in_row,
  input  logic [dgsp_pkg::VTX_W-1:0]    in_col,
  input  logic [dgsp_pkg::WGT_W-1:0]    in_weight,
  input  logic [dgsp_pkg::VTX_W-1:0]    in_source,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [dgsp_pkg::VTX_W-1:0]    out_vertex,
  output logic [dgsp_pkg::DIST_W-1:0]   out_distance,
  output logic                          out_reachable,
  output logic                          out_last
);
  import dgsp_pkg::*;

  localparam int NN     = NUM_VERTICES * NUM_VERTICES;
  localparam int WAW    = $clog2(NN);
  localparam int VW     = $clog2(NUM_VERTICES);
  localparam int CW     = $clog2(NUM_VERTICES + 1);
  localparam int REPORT = (NUM_VERTICES < MAX_REPORT) ? NUM_VERTICES : MAX_REPORT;
  localparam int EW     = $bits(dist_entry_t);

  localparam dist_entry_t SRC_ENTRY = '{settled: 1'b0, reached: 1'b1, dist_val: '0};

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_RELAX,
    S_OUT_RD,
    S_OUT_LD,
    S_OUT_HOLD
  } state_t;

  state_t            state_r;
  logic [WAW-1:0]    clr_r;
  logic [CW-1:0]     cnt_r;
  logic [VW-1:0]     idx_r;
  logic [VW-1:0]     u_r;
  logic [VTX_W-1:0]  src_r;
  logic [DIST_W-1:0] best_r;
  logic              found_r;
  logic              pend_r;

  logic              out_valid_r;
  logic [VTX_W-1:0]  out_vertex_r;
  logic [DIST_W-1:0] out_distance_r;
  logic              out_reachable_r;
  logic              out_last_r;

  logic              wram_we;
  logic [WAW-1:0]    wram_waddr;
  logic [WGT_W-1:0]  wram_wdata;
  logic [WAW-1:0]    wram_raddr;
  logic [WGT_W-1:0]  wram_rdata;

  logic              dram_we;
  logic [VW-1:0]     dram_waddr;
  logic [EW-1:0]     dram_wdata;
  logic [VW-1:0]     dram_raddr;
  logic [EW-1:0]     dram_rdata;

  dist_entry_t       rd_entry;
  relax_res_t        relax_res;
  logic              issue;
  logic              take;
  logic              load_ok;

  assign rd_entry = dram_rdata;
  assign issue    = (cnt_r != CW'(NUM_VERTICES));
  assign take     = rd_entry.reached && !rd_entry.settled &&
                    (!found_r || rd_entry.dist_val < best_r);
  assign load_ok  = (int'(in_row) < NUM_VERTICES) && (int'(in_col) < NUM_VERTICES);

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_vertex    = out_vertex_r;
  assign out_distance  = out_distance_r;
  assign out_reachable = out_reachable_r;
  assign out_last      = out_last_r;

  dgsp_relax u_relax (
    .best    (best_r),
    .wgt     (wram_rdata),
    .cur     (rd_entry),
    .is_self (idx_r == u_r),
    .res     (relax_res)
  );

  dgsp_ram #(
    .WIDTH (WGT_W),
    .DEPTH (NN)
  ) u_wram (
    .clk   (clk),
    .we    (wram_we),
    .waddr (wram_waddr),
    .wdata (wram_wdata),
    .raddr (wram_raddr),
    .rdata (wram_rdata)
  );

  dgsp_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_VERTICES)
  ) u_dram (
    .clk   (clk),
    .we    (dram_we),
    .waddr (dram_waddr),
    .wdata (dram_wdata),
    .raddr (dram_raddr),
    .rdata (dram_rdata)
  );

  always_comb begin
    wram_we    = 1'b0;
    wram_waddr = clr_r;
    wram_wdata = '0;
    wram_raddr = WAW'(int'(u_r) * NUM_VERTICES + int'(cnt_r[VW-1:0]));
    dram_we    = 1'b0;
    dram_waddr = cnt_r[VW-1:0];
    dram_wdata = '0;
    dram_raddr = cnt_r[VW-1:0];
    if (state_r == S_CLEAR) begin
      wram_we = 1'b1;
    end
    if (state_r == S_IDLE && in_valid && in_req_type == REQ_LOAD && load_ok) begin
      wram_we    = 1'b1;
      wram_waddr = WAW'(int'(in_row) * NUM_VERTICES + int'(in_col));
      wram_wdata = in_weight;
    end
    if (state_r == S_INIT) begin
      dram_we = 1'b1;
      if (int'(cnt_r) == int'(src_r)) begin
        dram_wdata = SRC_ENTRY;
      end
    end
    if (state_r == S_RELAX && pend_r) begin
      dram_we    = relax_res.wr;
      dram_waddr = idx_r;
      dram_wdata = relax_res.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == WAW'(NN - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_req_type == REQ_RUN) begin
            src_r   <= in_source;
            cnt_r   <= '0;
            state_r <= S_INIT;
          end
        end
        S_INIT: begin
          if (cnt_r == CW'(NUM_VERTICES - 1)) begin
            cnt_r   <= '0;
            found_r <= 1'b0;
            pend_r  <= 1'b0;
            state_r <= S_SCAN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_SCAN: begin
          pend_r <= issue;
          if (issue) begin
            cnt_r <= cnt_r + 1'b1;
            idx_r <= cnt_r[VW-1:0];
          end
          if (pend_r && take) begin
            found_r <= 1'b1;
            best_r  <= rd_entry.dist_val;
            u_r     <= idx_r;
          end
          if (!issue && !pend_r) begin
            cnt_r   <= '0;
            state_r <= found_r ? S_RELAX : S_OUT_RD;
          end
        end
        S_RELAX: begin
          pend_r <= issue;
          if (issue) begin
            cnt_r <= cnt_r + 1'b1;
            idx_r <= cnt_r[VW-1:0];
          end
          if (!issue && !pend_r) begin
            cnt_r   <= '0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_OUT_RD: begin
          state_r <= S_OUT_LD;
        end
        S_OUT_LD: begin
          out_vertex_r    <= VTX_W'(cnt_r);
          out_distance_r  <= rd_entry.reached ? rd_entry.dist_val : '0;
          out_reachable_r <= rd_entry.reached;
          out_last_r      <= (cnt_r == CW'(REPORT - 1));
          out_valid_r     <= 1'b1;
          state_r         <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              cnt_r   <= cnt_r + 1'b1;
              state_r <= S_OUT_RD;
            end
          end
        end
        default: begin
          state_r <= S_CLEAR;
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while a result is pending");

  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_req_type == REQ_RUN) |=> (!in_ready && !out_valid))
    else $error("block not busy after run item");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> in_ready)
    else $error("block not idle after last result");

  a_relax_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RELAX && dram_we) |-> (dram_waddr != dram_raddr))
    else $error("relax write collides with read");

endmodule

`default_nettype wire

// ----- tb/tb_dense_graph_shortest_paths.sv -----
// Testbench for dense_graph_shortest_paths: loads edge weights, runs searches
// and checks every reported vertex against a shortest path predictor kept here.
// Depends on dgsp_pkg and the dense_graph_shortest_paths RTL.
`timescale 1ns / 100ps

module tb;
  import dgsp_pkg::*;

  localparam int NUM_VTX     = 16;
  localparam int REPORT_CNT  = (NUM_VTX < MAX_REPORT) ? NUM_VTX : MAX_REPORT;
  localparam int ITEM_TARGET = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 50;

  typedef struct packed {
    logic [VTX_W-1:0]  vertex;
    logic [DIST_W-1:0] distance;
    logic              reachable;
    logic              last;
  } vtx_report_t;

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_req_type   = REQ_LOAD;
  logic [VTX_W-1:0]  in_row        = '0;
  logic [VTX_W-1:0]  in_col        = '0;
  logic [WGT_W-1:0]  in_weight     = '0;
  logic [VTX_W-1:0]  in_source     = '0;
  logic              out_ready     = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic [VTX_W-1:0]  out_vertex;
  logic [DIST_W-1:0] out_distance;
  logic              out_reachable;
  logic              out_last;

  logic [WGT_W-1:0] adj_weight [NUM_VTX][NUM_VTX];
  vtx_report_t      expected_dists [$];
  int               errors      = 0;
  int               sent_items  = 0;
  int               next_gap    = 0;
  int               sink_hold   = 0;
  bit               send_steady = 1'b0;
  bit               sink_steady = 1'b0;

  dense_graph_shortest_paths #(
    .NUM_VERTICES(NUM_VTX)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_row       (in_row),
    .in_col       (in_col),
    .in_weight    (in_weight),
    .in_source    (in_source),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_vertex   (out_vertex),
    .out_distance (out_distance),
    .out_reachable(out_reachable),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  initial begin
    for (int r = 0; r < NUM_VTX; r++) begin
      for (int c = 0; c < NUM_VTX; c++) begin
        adj_weight[r][c] = '0;
      end
    end
  end

  task automatic solve_distances(input logic [VTX_W-1:0] src);
    logic [DIST_W-1:0] path_dist [NUM_VTX];
    logic              reached [NUM_VTX];
    logic              settled [NUM_VTX];
    logic              found;
    int                u;
    logic [DIST_W:0]   cand;
    vtx_report_t       rep;
    for (int v = 0; v < NUM_VTX; v++) begin
      path_dist[v] = '0;
      reached[v]   = 1'b0;
      settled[v]   = 1'b0;
    end
    if (src < NUM_VTX) begin
      reached[src] = 1'b1;
    end
    for (int i = 0; i < NUM_VTX; i++) begin
      found = 1'b0;
      u     = 0;
      for (int v = 0; v < NUM_VTX; v++) begin
        if (reached[v] && !settled[v] && (!found || path_dist[v] < path_dist[u])) begin
          found = 1'b1;
          u     = v;
        end
      end
      if (!found) break;
      settled[u] = 1'b1;
      for (int v = 0; v < NUM_VTX; v++) begin
        if (!settled[v] && adj_weight[u][v] != '0) begin
          cand = {1'b0, path_dist[u]} + (DIST_W + 1)'(adj_weight[u][v]);
          if (cand > {1'b0, DIST_MAX}) cand = {1'b0, DIST_MAX};
          if (!reached[v] || cand[DIST_W-1:0] < path_dist[v]) begin
            path_dist[v] = cand[DIST_W-1:0];
            reached[v]   = 1'b1;
          end
        end
      end
    end
    for (int v = 0; v < REPORT_CNT; v++) begin
      rep.vertex    = VTX_W'(v);
      rep.distance  = reached[v] ? path_dist[v] : '0;
      rep.reachable = reached[v];
      rep.last      = (v == REPORT_CNT - 1);
      expected_dists.push_back(rep);
    end
  endtask

  task automatic send_item(input logic req, input logic [VTX_W-1:0] row,
                           input logic [VTX_W-1:0] col, input logic [WGT_W-1:0] weight,
                           input logic [VTX_W-1:0] source);
    repeat (next_gap) @(posedge clk);
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_row      <= row;
    in_col      <= col;
    in_weight   <= weight;
    in_source   <= source;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    if (req == REQ_LOAD) begin
      if (row < NUM_VTX && col < NUM_VTX) adj_weight[row][col] = weight;
    end else begin
      solve_distances(source);
    end
    next_gap = send_steady ? 0 : $urandom_range(0, 8);
    if (next_gap > 0) in_valid <= 1'b0;
  endtask

  task automatic load_edge(input logic [VTX_W-1:0] row, input logic [VTX_W-1:0] col,
                           input logic [WGT_W-1:0] weight);
    send_item(REQ_LOAD, row, col, weight, VTX_W'($urandom));
  endtask

  task automatic run_from(input logic [VTX_W-1:0] source);
    send_item(REQ_RUN, VTX_W'($urandom), VTX_W'($urandom), WGT_W'($urandom), source);
  endtask

  // hold the input side until every expected result has come
  task automatic wait_drained();
    if (next_gap == 0) in_valid <= 1'b0;
    next_gap = 0;
    do @(posedge clk); while (expected_dists.size() != 0);
  endtask

  task automatic clear_graph();
    for (int r = 0; r < NUM_VTX; r++) begin
      for (int c = 0; c < NUM_VTX; c++) begin
        if (adj_weight[r][c] != '0) load_edge(VTX_W'(r), VTX_W'(c), '0);
      end
    end
  endtask

  function automatic logic [WGT_W-1:0] rand_weight();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 5) return '0;
    else if (pick < 13) return WGT_W'($urandom_range(1, 8));
    else if (pick < 17) return WGT_W'($urandom_range(1, 4096));
    else return WGT_W'($urandom);
  endfunction

  task automatic test_empty_graph();
    send_steady = 1'b1;
    run_from(0);
    run_from(VTX_W'(NUM_VTX - 1));
    send_steady = 1'b0;
  endtask

  task automatic test_directed_paths();
    load_edge(0, 15, 16'hFFFF);
    load_edge(0, 1, 1);
    load_edge(1, 2, 1);
    load_edge(2, 15, 1);
    load_edge(15, 7, 1);
    load_edge(3, 3, 5);
    load_edge(15, 0, 16'h8000);
    load_edge(7, 14, 16'h5555);
    load_edge(14, 8, 16'hAAAA);
    run_from(0);
    run_from(15);
    run_from(3);
  endtask

  task automatic test_overwrite_and_ties();
    load_edge(2, 15, 0);
    load_edge(0, 4, 2);
    load_edge(1, 4, 1);
    load_edge(2, 5, 2);
    load_edge(4, 5, 2);
    run_from(0);
    wait_drained();
    run_from(1);
  endtask

  task automatic test_long_chain();
    int order [NUM_VTX];
    int j;
    int tmp;
    clear_graph();
    for (int k = 0; k < NUM_VTX - 1; k++) load_edge(VTX_W'(k), VTX_W'(k + 1), 16'hFFFF);
    run_from(0);
    run_from(VTX_W'(NUM_VTX - 1));
    clear_graph();
    for (int k = 0; k < NUM_VTX; k++) order[k] = k;
    for (int k = NUM_VTX - 1; k > 0; k--) begin
      j        = $urandom_range(0, k);
      tmp      = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < NUM_VTX - 1; k++) begin
      load_edge(VTX_W'(order[k]), VTX_W'(order[k + 1]),
                WGT_W'($urandom_range(16'hF000, 16'hFFFF)));
    end
    run_from(VTX_W'(order[0]));
    run_from(VTX_W'(order[NUM_VTX / 2]));
  endtask

  task automatic test_random_graphs();
    while (sent_items < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) send_steady = ~send_steady;
      if ($urandom_range(0, 4) == 0) sink_steady = ~sink_steady;
      if ($urandom_range(0, 9) == 0) clear_graph();
      repeat ($urandom_range(1, 12)) begin
        load_edge(VTX_W'($urandom), VTX_W'($urandom), rand_weight());
      end
      if ($urandom_range(0, 9) == 0) wait_drained();
      repeat ($urandom_range(1, 2)) run_from(VTX_W'($urandom));
    end
  endtask

  function automatic void check_report();
    vtx_report_t exp_r;
    if (expected_dists.size() == 0) begin
      $error("unexpected result: vertex %0d distance %0d", out_vertex, out_distance);
      errors++;
      return;
    end
    exp_r = expected_dists.pop_front();
    if (out_vertex !== exp_r.vertex) begin
      $error("vertex: expected %0d, actual %0d", exp_r.vertex, out_vertex);
      errors++;
    end
    if (out_distance !== exp_r.distance) begin
      $error("distance: expected %0d, actual %0d", exp_r.distance, out_distance);
      errors++;
    end
    if (out_reachable !== exp_r.reachable) begin
      $error("reachable: expected %0b, actual %0b", exp_r.reachable, out_reachable);
      errors++;
    end
    if (out_last !== exp_r.last) begin
      $error("last: expected %0b, actual %0b", exp_r.last, out_last);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_hold = 0;
    end else if (out_valid && out_ready) begin
      check_report();
      sink_hold = sink_steady ? 0 : $urandom_range(0, 8);
      out_ready <= (sink_hold == 0);
    end else if (sink_hold > 0) begin
      sink_hold--;
      out_ready <= (sink_hold == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("dense_graph_shortest_paths test failed");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_graph();
    test_directed_paths();
    test_overwrite_and_ties();
    test_long_chain();
    test_random_graphs();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("dense_graph_shortest_paths test passed");
    end else begin
      $display("dense_graph_shortest_paths test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/dgsp_pkg.sv
design/dgsp_ram.sv
design/dgsp_relax.sv
design/dense_graph_shortest_paths.sv
tb/tb_dense_graph_shortest_paths.sv
